FILE: rtl/dti_pkg.sv
// ----------------------------------------------------------------------------
// dti_pkg: shared definitions for the decision tree inference core
// Operation codes, status codes, port widths and default parameter values.
// ----------------------------------------------------------------------------
package dti_pkg;

    // Port widths fixed by the item format
    localparam int FUNC_W       = 2;
    localparam int INDEX_W      = 8;
    localparam int SELECT_W     = 4;
    localparam int VALUE_W      = 16;
    localparam int CHILD_W      = 8;
    localparam int CLASS_PORT_W = 8;
    localparam int STATUS_W     = 2;

    // Default configuration
    localparam int DEF_NODE_COUNT    = 256;
    localparam int DEF_FEATURE_COUNT = 16;
    localparam int DEF_FEATURE_WIDTH = 16;
    localparam int DEF_CLASS_WIDTH   = 8;

    // Operation codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_LOAD_NODE    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_FEATURE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLASSIFY     = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_BUILT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STEP_LIMIT = 2'd2;

endpackage

FILE: rtl/dti_branch_eval.sv
// ----------------------------------------------------------------------------
// dti_branch_eval: node test and child select
// Compare one feature with the node threshold and pick the next node index.
// ----------------------------------------------------------------------------
module dti_branch_eval #(
    parameter int NODE_COUNT    = dti_pkg::DEF_NODE_COUNT,
    parameter int FEATURE_WIDTH = dti_pkg::DEF_FEATURE_WIDTH
) (
    input  logic                                compare_kind,
    input  logic signed [FEATURE_WIDTH-1:0]     feature,
    input  logic signed [FEATURE_WIDTH-1:0]     thr,
    input  logic [$clog2(NODE_COUNT)-1:0]       pass_idx,
    input  logic [$clog2(NODE_COUNT)-1:0]       fail_idx,
    output logic [$clog2(NODE_COUNT)-1:0]       next_idx
);

    logic test_holds;

    // kind 0: equality, kind 1: signed less-than
    always_comb
    begin
        if (compare_kind)
        begin
            test_holds = (feature < thr);
        end
        else
        begin
            test_holds = (feature == thr);
        end
    end

    assign next_idx = test_holds ? pass_idx : fail_idx;

endmodule

FILE: rtl/decision_tree_inference_core.sv
// ----------------------------------------------------------------------------
// decision_tree_inference_core: binary decision tree classifier
// Holds a node table and a feature store in synchronous memories and walks
// the tree one node at a time for each classify item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | into core | in_valid / in_ready   | func, index, node word fields,
//          |           |                       | feature_value
//  out     | from core | out_valid / out_ready | predicted_class, status
//
//  Load-node, load-feature and unused-code items leave the core in ST_IDLE,
//  ready for the next item. A classify item holds in_ready low from acceptance
//  until its result is loaded; the walk passes at most NODE_COUNT - 1 test
//  nodes. Each test node costs one node-memory read followed by one
//  feature-memory read. Reset clears the control state only; both memories
//  come up undefined and need no clearing pass. A stalled output holds the
//  finished walk in place until the result register frees, while earlier
//  results drain.
// ----------------------------------------------------------------------------
module decision_tree_inference_core #(
    parameter int NODE_COUNT    = dti_pkg::DEF_NODE_COUNT,
    parameter int FEATURE_COUNT = dti_pkg::DEF_FEATURE_COUNT,
    parameter int FEATURE_WIDTH = dti_pkg::DEF_FEATURE_WIDTH,
    parameter int CLASS_WIDTH   = dti_pkg::DEF_CLASS_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dti_pkg::FUNC_W-1:0]            func,
    input  logic [dti_pkg::INDEX_W-1:0]           index,
    input  logic                                  leaf_flag,
    input  logic                                  compare_kind,
    input  logic [dti_pkg::SELECT_W-1:0]          feature_select,
    input  logic signed [dti_pkg::VALUE_W-1:0]    threshold,
    input  logic [dti_pkg::CHILD_W-1:0]           fail_child,
    input  logic [dti_pkg::CHILD_W-1:0]           pass_child,
    input  logic [dti_pkg::CLASS_PORT_W-1:0]      leaf_class,
    input  logic signed [dti_pkg::VALUE_W-1:0]    feature_value,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [dti_pkg::CLASS_PORT_W-1:0]      predicted_class,
    output logic [dti_pkg::STATUS_W-1:0]          status
);

    localparam int NIDX_W = $clog2(NODE_COUNT);
    localparam int FIDX_W = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int CHILD_CODES  = 1 << dti_pkg::CHILD_W;
    localparam int SELECT_CODES = 1 << dti_pkg::SELECT_W;
    localparam logic [NIDX_W-1:0] LAST_STEP = NIDX_W'(NODE_COUNT - 1);

    // Walk sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NODE = 2'd1;  // node word on the read register
    localparam logic [1:0] ST_FEAT = 2'd2;  // tested feature on the read register

    typedef struct packed {
        logic                             leaf;
        logic                             kind;
        logic [FIDX_W-1:0]                sel;
        logic signed [FEATURE_WIDTH-1:0]  thr;
        logic [NIDX_W-1:0]                fail;
        logic [NIDX_W-1:0]                pass;
        logic [CLASS_WIDTH-1:0]           cls;
    } node_t;

    typedef logic [NIDX_W-1:0] child_map_t [CHILD_CODES];
    typedef logic [FIDX_W-1:0] select_map_t [SELECT_CODES];

    // Child and select codes wrap into the table sizes; fold them once at
    // load time through constant tables so the walk reads ready indices.
    function automatic child_map_t build_child_map();
        child_map_t m;
        for (int i = 0; i < CHILD_CODES; i++)
        begin
            m[i] = NIDX_W'(i % NODE_COUNT);
        end
        return m;
    endfunction

    function automatic select_map_t build_select_map();
        select_map_t m;
        for (int i = 0; i < SELECT_CODES; i++)
        begin
            m[i] = FIDX_W'(i % FEATURE_COUNT);
        end
        return m;
    endfunction

    localparam child_map_t  CHILD_MAP  = build_child_map();
    localparam select_map_t SELECT_MAP = build_select_map();

    // Storage
    node_t                           node_mem [NODE_COUNT];
    logic signed [FEATURE_WIDTH-1:0] feat_mem [FEATURE_COUNT];
    node_t                           node_q;
    logic signed [FEATURE_WIDTH-1:0] feat_q;

    // Control state
    logic [1:0]                      state_reg, state_next;
    logic [NIDX_W-1:0]               steps_reg, steps_next;
    logic                            built_reg, built_next;
    logic                            out_valid_reg, out_valid_next;
    logic [dti_pkg::CLASS_PORT_W-1:0] class_reg;
    logic [dti_pkg::STATUS_W-1:0]    status_reg;

    // Memory port controls
    logic                            node_wr_en;
    node_t                           node_wr;
    logic                            node_rd_en;
    logic [NIDX_W-1:0]               node_rd_addr;
    logic                            feat_wr_en;
    logic                            feat_rd_en;

    // Walk results
    logic                            accept;
    logic                            slot_free;
    logic                            load_out;
    logic [dti_pkg::CLASS_PORT_W-1:0] res_class;
    logic [dti_pkg::STATUS_W-1:0]    res_status;
    logic [NIDX_W-1:0]               next_idx;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    // Result register can take a new result this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // Node word as written by a load-node item
    assign node_wr.leaf = leaf_flag;
    assign node_wr.kind = compare_kind;
    assign node_wr.sel  = SELECT_MAP[feature_select];
    assign node_wr.thr  = FEATURE_WIDTH'(threshold);
    assign node_wr.fail = CHILD_MAP[fail_child];
    assign node_wr.pass = CHILD_MAP[pass_child];
    assign node_wr.cls  = CLASS_WIDTH'(leaf_class);

    dti_branch_eval #(
        .NODE_COUNT    (NODE_COUNT),
        .FEATURE_WIDTH (FEATURE_WIDTH)
    ) u_branch_eval (
        .compare_kind (node_q.kind),
        .feature      (feat_q),
        .thr          (node_q.thr),
        .pass_idx     (node_q.pass),
        .fail_idx     (node_q.fail),
        .next_idx     (next_idx)
    );

    // Sequencer: loads are handled in ST_IDLE, classify walks node then feature
    always_comb
    begin
        state_next   = state_reg;
        steps_next   = steps_reg;
        built_next   = built_reg;
        node_wr_en   = 1'b0;
        feat_wr_en   = 1'b0;
        node_rd_en   = 1'b0;
        node_rd_addr = '0;
        feat_rd_en   = 1'b0;
        load_out     = 1'b0;
        res_class    = '0;
        res_status   = dti_pkg::STATUS_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        dti_pkg::FUNC_LOAD_NODE:
                        begin
                            // Drop writes beyond the table
                            if (int'(index) < NODE_COUNT)
                            begin
                                node_wr_en = 1'b1;
                                if (!leaf_flag)
                                begin
                                    built_next = 1'b1;
                                end
                            end
                        end
                        dti_pkg::FUNC_LOAD_FEATURE:
                        begin
                            if (int'(index) < FEATURE_COUNT)
                            begin
                                feat_wr_en = 1'b1;
                            end
                        end
                        dti_pkg::FUNC_CLASSIFY:
                        begin
                            // Start at the root; the tree check waits for ST_NODE
                            node_rd_en = 1'b1;
                            steps_next = '0;
                            state_next = ST_NODE;
                        end
                        default:
                        begin
                            // Unused code: take the item, do nothing
                        end
                    endcase
                end
            end

            ST_NODE:
            begin
                priority if (!built_reg)
                begin
                    if (slot_free)
                    begin
                        load_out   = 1'b1;
                        res_status = dti_pkg::STATUS_NOT_BUILT;
                        state_next = ST_IDLE;
                    end
                end
                else if (node_q.leaf)
                begin
                    if (slot_free)
                    begin
                        load_out   = 1'b1;
                        res_class  = dti_pkg::CLASS_PORT_W'(node_q.cls);
                        state_next = ST_IDLE;
                    end
                end
                else if (steps_reg == LAST_STEP)
                begin
                    // Last node the walk may visit is still a test
                    if (slot_free)
                    begin
                        load_out   = 1'b1;
                        res_status = dti_pkg::STATUS_STEP_LIMIT;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    feat_rd_en = 1'b1;
                    state_next = ST_FEAT;
                end
            end

            ST_FEAT:
            begin
                // Advance to the chosen child
                node_rd_en   = 1'b1;
                node_rd_addr = next_idx;
                steps_next   = steps_reg + NIDX_W'(1);
                state_next   = ST_NODE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Node memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (node_wr_en)
        begin
            node_mem[NIDX_W'(index)] <= node_wr;
        end
        if (node_rd_en)
        begin
            node_q <= node_mem[node_rd_addr];
        end
    end

    // Feature memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (feat_wr_en)
        begin
            feat_mem[FIDX_W'(index)] <= FEATURE_WIDTH'(feature_value);
        end
        if (feat_rd_en)
        begin
            feat_q <= feat_mem[node_q.sel];
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            class_reg  <= res_class;
            status_reg <= res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            steps_reg     <= '0;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign predicted_class = class_reg;
    assign status          = status_reg;

endmodule

FILE: rtl/dti_checker.sv
// ----------------------------------------------------------------------------
// dti_checker: port-level checks for the decision tree inference core
// Watches the handshakes and results and is bound to the top level.
// ----------------------------------------------------------------------------
module dti_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [dti_pkg::FUNC_W-1:0]         func,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [dti_pkg::CLASS_PORT_W-1:0]   predicted_class,
    input logic [dti_pkg::STATUS_W-1:0]       status
);

    // Hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(predicted_class) && $stable(status))
        else $error("stalled result changed or dropped");

    // Error results carry class zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != dti_pkg::STATUS_OK) |-> (predicted_class == '0))
        else $error("error result with nonzero class");

    // Input is not ready in the cycle after a classify item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == dti_pkg::FUNC_CLASSIFY) |=> !in_ready)
        else $error("input taken right after classify");

    // A new result only appears after a walk, never straight from idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the core was idle");

    // Status stays within its defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == dti_pkg::STATUS_OK) || (status == dti_pkg::STATUS_NOT_BUILT)
                      || (status == dti_pkg::STATUS_STEP_LIMIT))
        else $error("undefined status code");

endmodule

bind decision_tree_inference_core dti_checker u_dti_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .predicted_class (predicted_class),
    .status          (status)
);

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for decision_tree_inference_core
// Loads node words and features, runs classify walks and checks every result
// against a cycle-free tree walker kept inside the bench. Covers the unbuilt
// tree, both compare kinds at the value extremes, dropped and unused items,
// random trees with random traffic and idling on both channels, a long output
// stall and a walk that runs into the step guard.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES         = dti_pkg::DEF_NODE_COUNT;
    localparam int FEATS         = dti_pkg::DEF_FEATURE_COUNT;
    localparam int NODE_IDX_W    = $clog2(NODES);
    localparam int FEAT_IDX_W    = $clog2(FEATS);
    localparam int MAX_IDLE      = 6;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int HOLD_OFF      = 400;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_CAP    = 100;

    // Field types, one per port
    typedef logic [dti_pkg::FUNC_W-1:0]         func_t;
    typedef logic [dti_pkg::INDEX_W-1:0]        index_t;
    typedef logic [dti_pkg::SELECT_W-1:0]       select_t;
    typedef logic signed [dti_pkg::VALUE_W-1:0] value_t;
    typedef logic [dti_pkg::CHILD_W-1:0]        child_t;
    typedef logic [dti_pkg::CLASS_PORT_W-1:0]   class_t;
    typedef logic [dti_pkg::STATUS_W-1:0]       status_t;
    typedef logic [NODE_IDX_W-1:0]              node_idx_t;
    typedef logic [FEAT_IDX_W-1:0]              feat_idx_t;

    // func code with no operation behind it
    localparam func_t FUNC_UNUSED = 2'd3;

    // compare kinds of a test node
    localparam logic KIND_EQUAL = 1'b0;
    localparam logic KIND_BELOW = 1'b1;

    // One input item, one field per port
    typedef struct {
        func_t   func;
        index_t  index;
        logic    leaf_flag;
        logic    compare_kind;
        select_t feature_select;
        value_t  threshold;
        child_t  fail_child;
        child_t  pass_child;
        class_t  leaf_class;
        value_t  feature_value;
    } tree_item_t;

    // One stored node word
    typedef struct {
        logic    leaf;
        logic    kind;
        select_t sel;
        value_t  thr;
        child_t  fail_to;
        child_t  pass_to;
        class_t  cls;
    } node_word_t;

    // One classification outcome
    typedef struct {
        class_t  cls;
        status_t status;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    logic    in_valid;
    logic    in_ready;
    func_t   func;
    index_t  index;
    logic    leaf_flag;
    logic    compare_kind;
    select_t feature_select;
    value_t  threshold;
    child_t  fail_child;
    child_t  pass_child;
    class_t  leaf_class;
    value_t  feature_value;

    logic    out_valid;
    logic    out_ready;
    class_t  predicted_class;
    status_t status;

    // Shadow copy of the block's state, updated as each item is accepted
    node_word_t node_mem [NODES];
    bit         node_written [NODES];
    value_t     feature_mem [FEATS];
    bit         tree_built;

    // Outcomes of accepted classify items, oldest first
    verdict_t pending_verdicts [$];

    // Shared run controls: idling on/off for both sides, receiver hold-off
    bit gaps_on = 1'b1;
    int hold_off_len;

    int cycle_count;
    int mismatch_count;
    int items_sent;
    int results_checked;
    int ok_results;
    int unbuilt_results;
    int limit_results;
    int deepest_walk;

    decision_tree_inference_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .index           (index),
        .leaf_flag       (leaf_flag),
        .compare_kind    (compare_kind),
        .feature_select  (feature_select),
        .threshold       (threshold),
        .fail_child      (fail_child),
        .pass_child      (pass_child),
        .leaf_class      (leaf_class),
        .feature_value   (feature_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .predicted_class (predicted_class),
        .status          (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tree walker: follow the stored tree from node 0 the way the block
    // must, stopping at a leaf or when the step guard trips.
    // ------------------------------------------------------------------
    function automatic verdict_t walk_tree();
        verdict_t  v;
        node_idx_t pos;
        int        steps;
        value_t    f;
        logic      hold;
        child_t    next_to;
        pos = '0;
        steps = 0;
        v.cls = '0;
        v.status = dti_pkg::STATUS_NOT_BUILT;
        // an all-leaf or empty tree never starts a walk
        if (!tree_built)
            return v;
        // the walk may visit at most NODES nodes; the last one must be a leaf
        while (!node_mem[pos].leaf && steps + 1 < NODES)
        begin
            f = feature_mem[feat_idx_t'(node_mem[pos].sel % FEATS)];
            if (node_mem[pos].kind == KIND_BELOW)
                hold = (f < node_mem[pos].thr);
            else
                hold = (f == node_mem[pos].thr);
            next_to = hold ? node_mem[pos].pass_to : node_mem[pos].fail_to;
            pos = node_idx_t'(next_to % NODES);
            steps++;
        end
        if (steps > deepest_walk)
            deepest_walk = steps;
        if (node_mem[pos].leaf)
        begin
            v.cls = node_mem[pos].cls;
            v.status = dti_pkg::STATUS_OK;
        end
        else
            v.status = dti_pkg::STATUS_STEP_LIMIT;
        return v;
    endfunction

    // Advance the shadow state by one accepted item
    function automatic void apply_item(input tree_item_t it);
        node_idx_t n;
        n = node_idx_t'(it.index);
        case (it.func)
            dti_pkg::FUNC_LOAD_NODE:
                if (it.index < NODES)
                begin
                    node_mem[n].leaf    = it.leaf_flag;
                    node_mem[n].kind    = it.compare_kind;
                    node_mem[n].sel     = it.feature_select;
                    node_mem[n].thr     = it.threshold;
                    node_mem[n].fail_to = it.fail_child;
                    node_mem[n].pass_to = it.pass_child;
                    node_mem[n].cls     = it.leaf_class;
                    node_written[n]     = 1'b1;
                    // the first test node marks the tree as built for good
                    if (!it.leaf_flag)
                        tree_built = 1'b1;
                end
            dti_pkg::FUNC_LOAD_FEATURE:
                if (it.index < FEATS)
                    feature_mem[feat_idx_t'(it.index)] = it.feature_value;
            dti_pkg::FUNC_CLASSIFY:
                pending_verdicts = {pending_verdicts, walk_tree()};
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item builders. Every field starts random so that fields an item
    // does not use still toggle; the used ones are then set.
    // ------------------------------------------------------------------
    function automatic tree_item_t noise_item();
        tree_item_t it;
        it.func           = func_t'($urandom);
        it.index          = index_t'($urandom);
        it.leaf_flag      = 1'($urandom);
        it.compare_kind   = 1'($urandom);
        it.feature_select = select_t'($urandom);
        it.threshold      = value_t'($urandom);
        it.fail_child     = child_t'($urandom);
        it.pass_child     = child_t'($urandom);
        it.leaf_class     = class_t'($urandom);
        it.feature_value  = value_t'($urandom);
        return it;
    endfunction

    function automatic tree_item_t op_item(input func_t code);
        tree_item_t it;
        it = noise_item();
        it.func = code;
        return it;
    endfunction

    function automatic tree_item_t leaf_node(input int idx, input int cls);
        tree_item_t it;
        it = noise_item();
        it.func       = dti_pkg::FUNC_LOAD_NODE;
        it.index      = index_t'(idx);
        it.leaf_flag  = 1'b1;
        it.leaf_class = class_t'(cls);
        return it;
    endfunction

    function automatic tree_item_t test_node(input int idx, input logic kind, input int sel,
                                             input value_t thr,
                                             input int fail_to, input int pass_to);
        tree_item_t it;
        it = noise_item();
        it.func           = dti_pkg::FUNC_LOAD_NODE;
        it.index          = index_t'(idx);
        it.leaf_flag      = 1'b0;
        it.compare_kind   = kind;
        it.feature_select = select_t'(sel);
        it.threshold      = thr;
        it.fail_child     = child_t'(fail_to);
        it.pass_child     = child_t'(pass_to);
        return it;
    endfunction

    function automatic tree_item_t feature_item(input int idx, input value_t val);
        tree_item_t it;
        it = noise_item();
        it.func          = dti_pkg::FUNC_LOAD_FEATURE;
        it.index         = index_t'(idx);
        it.feature_value = val;
        return it;
    endfunction

    // Value with extra weight on the signed extremes and around zero
    function automatic value_t rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return value_t'($urandom);
        endcase
    endfunction

    function automatic int rand_class();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 255;
            default: return int'($urandom_range(0, 255));
        endcase
    endfunction

    // Thresholds near the stored feature so that both children get taken
    function automatic value_t pick_threshold(input int sel);
        feat_idx_t s;
        s = feat_idx_t'(sel);
        case ($urandom_range(0, 4))
            0:       return feature_mem[s];
            1:       return feature_mem[s] + 16'sd1;
            2:       return feature_mem[s] - 16'sd1;
            3:       return rand_value();
            default: return value_t'($urandom);
        endcase
    endfunction

    // Random traffic item. Test nodes only point at written nodes with a
    // higher index, so the stored tree stays acyclic and every walk reads
    // written entries only.
    function automatic tree_item_t random_item();
        tree_item_t it;
        int roll;
        int idx;
        int sel;
        int c;
        int above [$];
        roll = int'($urandom_range(0, 99));
        if (roll < 60)
            it = op_item(dti_pkg::FUNC_CLASSIFY);
        else if (roll < 78)
        begin
            if ($urandom_range(0, 7) == 0)
                idx = int'($urandom_range(FEATS, 255));
            else
                idx = int'($urandom_range(0, FEATS - 1));
            it = feature_item(idx, rand_value());
        end
        else if (roll < 92)
        begin
            idx = int'($urandom_range(0, NODES - 1));
            for (c = idx + 1; c < NODES; c++)
                if (node_written[c])
                    above = {above, c};
            if (above.size() == 0 || $urandom_range(0, 2) == 0)
                it = leaf_node(idx, rand_class());
            else
            begin
                sel = int'($urandom_range(0, FEATS - 1));
                it = test_node(idx, 1'($urandom_range(0, 1)), sel, pick_threshold(sel),
                               above[$urandom_range(0, above.size() - 1)],
                               above[$urandom_range(0, above.size() - 1)]);
            end
        end
        else
            it = op_item(FUNC_UNUSED);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("ERROR cycle %0d: %s", cycle_count, what);
    endtask

    // Offer one item, hold it until accepted, then advance the shadow state.
    // Valid stays high after acceptance; the next call lowers it or reuses it.
    task automatic send_item(input tree_item_t it);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= it.func;
        index          <= it.index;
        leaf_flag      <= it.leaf_flag;
        compare_kind   <= it.compare_kind;
        feature_select <= it.feature_select;
        threshold      <= it.threshold;
        fail_child     <= it.fail_child;
        pass_child     <= it.pass_child;
        leaf_class     <= it.leaf_class;
        feature_value  <= it.feature_value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_item(it);
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_unbuilt_tree();
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));     // nothing loaded at all
        send_item(leaf_node(0, 255));
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));     // leaves alone do not build a tree
        send_item(op_item(FUNC_UNUSED));
        send_item(feature_item(255, 16'sh1234));        // out of range, dropped
    endtask

    task automatic test_compare_kinds();
        send_item(feature_item(0, 16'sh8000));
        send_item(feature_item(1, 16'sh7FFF));
        send_item(feature_item(2, 16'sh0000));
        send_item(feature_item(3, 16'shFFFF));
        send_item(leaf_node(1, 0));
        send_item(leaf_node(2, 165));
        // most negative value is below its successor
        send_item(test_node(0, KIND_BELOW, 0, 16'sh8001, 1, 2));
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));
        // equality at the top of the range
        send_item(test_node(0, KIND_EQUAL, 1, 16'sh7FFF, 1, 2));
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));
        // equal is not below
        send_item(test_node(0, KIND_BELOW, 1, 16'sh7FFF, 1, 2));
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));
        // minus one below zero: signed compare
        send_item(test_node(0, KIND_BELOW, 3, 16'sh0000, 1, 2));
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));
        // root pointing at itself runs into the step guard
        send_item(test_node(0, KIND_EQUAL, 2, 16'sh0000, 0, 0));
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));
        // restore an acyclic root; minus one differs from the most negative
        send_item(test_node(0, KIND_EQUAL, 3, 16'sh8000, 1, 2));
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));
    endtask

    // Write a random acyclic tree rooted at node 0, highest member first, so that
    // each test node's children are already written when it lands
    task automatic build_random_tree(output int size);
        bit chosen [NODES];
        int members [$];
        int count;
        int pick;
        int i;
        int sel;
        size = int'($urandom_range(3, 24));
        chosen = '{default: 1'b0};
        chosen[0] = 1'b1;
        count = 1;
        while (count < size)
        begin
            pick = int'($urandom_range(1, NODES - 1));
            if (!chosen[pick])
            begin
                chosen[pick] = 1'b1;
                count++;
            end
        end
        for (i = 0; i < NODES; i++)
            if (chosen[i])
                members = {members, i};
        for (i = size - 1; i >= 0; i--)
        begin
            if (i == size - 1 || (i > 0 && $urandom_range(0, 3) == 0))
                send_item(leaf_node(members[i], rand_class()));
            else
            begin
                sel = int'($urandom_range(0, FEATS - 1));
                send_item(test_node(members[i], 1'($urandom_range(0, 1)), sel,
                                    pick_threshold(sel),
                                    members[$urandom_range(i + 1, size - 1)],
                                    members[$urandom_range(i + 1, size - 1)]));
            end
        end
    endtask

    task automatic test_random_trees();
        tree_item_t it;
        int counted;
        int size;
        int k;
        // fill the whole feature store before any random test node reads it
        for (k = 0; k < FEATS; k++)
            send_item(feature_item(k, rand_value()));
        counted = FEATS;
        while (counted < RANDOM_ITEMS)
        begin
            // roughly one phase in four runs with no idling on either side
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 3))
            begin
                send_item(feature_item(int'($urandom_range(0, FEATS - 1)), rand_value()));
                counted++;
            end
            build_random_tree(size);
            counted += size;
            repeat ($urandom_range(10, 40))
            begin
                it = random_item();
                send_item(it);
                // dropped and unused items do not count toward the total
                if (it.func != FUNC_UNUSED &&
                    !(it.func == dti_pkg::FUNC_LOAD_FEATURE && it.index >= FEATS))
                    counted++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    // Hold the output off for a long stretch while classify items keep
    // coming back to back, so the core fills up and stalls its input
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_off_len = HOLD_OFF;
        repeat (16) send_item(op_item(dti_pkg::FUNC_CLASSIFY));
        wait_drained();
        gaps_on = 1'b1;
        repeat (24) send_item(random_item());
        wait_drained();
    endtask

    // Chain through every node: the longest legal walk ends on a leaf at the
    // last allowed visit; turning that leaf into a test trips the guard
    task automatic test_deep_walk();
        int i;
        int sel;
        send_item(leaf_node(NODES - 1, rand_class()));
        for (i = NODES - 2; i >= 0; i--)
        begin
            sel = int'($urandom_range(0, FEATS - 1));
            send_item(test_node(i, 1'($urandom_range(0, 1)), sel, rand_value(),
                                i + 1, i + 1));
        end
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));
        sel = int'($urandom_range(0, FEATS - 1));
        send_item(test_node(NODES - 1, 1'($urandom_range(0, 1)), sel, rand_value(), 0, 0));
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));
        send_item(leaf_node(NODES - 1, rand_class()));
        send_item(op_item(dti_pkg::FUNC_CLASSIFY));
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall per result, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            stall = gaps_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            // leave early when a hold-off is asked for
            while (!out_valid && hold_off_len == 0)
                @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest outstanding outcome
    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch($sformatf("result class %0d status %0d with none pending",
                                          predicted_class, status));
            else
            begin
                want = pending_verdicts.pop_front();
                results_checked++;
                if (predicted_class !== want.cls)
                    report_mismatch($sformatf("predicted_class %0d, want %0d",
                                              predicted_class, want.cls));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                case (want.status)
                    dti_pkg::STATUS_OK:         ok_results++;
                    dti_pkg::STATUS_NOT_BUILT:  unbuilt_results++;
                    dti_pkg::STATUS_STEP_LIMIT: limit_results++;
                    default:                    ;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_verdicts.size());
            $display("decision_tree_inference_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        int n;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        func           <= '0;
        index          <= '0;
        leaf_flag      <= 1'b0;
        compare_kind   <= 1'b0;
        feature_select <= '0;
        threshold      <= '0;
        fail_child     <= '0;
        pass_child     <= '0;
        leaf_class     <= '0;
        feature_value  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_unbuilt_tree();
        test_compare_kinds();
        test_random_trees();
        test_backpressure();
        test_deep_walk();

        // drain with a bound, then let the core settle
        in_valid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && pending_verdicts.size() != 0; n++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never came", pending_verdicts.size()));

        $display("Ran %0d items in %0d cycles; %0d results checked: %0d leaf, %0d unbuilt tree,",
                 items_sent, cycle_count, results_checked, ok_results, unbuilt_results);
        $display("%0d step guard; longest walk %0d node tests, %0d errors.",
                 limit_results, deepest_walk, mismatch_count);
        if (mismatch_count == 0)
            $display("decision_tree_inference_core: match");
        else
            $display("decision_tree_inference_core: mismatch");
        $finish;
    end

endmodule
